// File: src/swd_pkg.sv
package swd_pkg;

	// Width of a latched coordinate
	localparam int COORD_BITS = 16;
	// Width of a threshold register
	localparam int THR_BITS = 15;
	// Signed compare width that holds a coordinate and a zero-extended threshold
	localparam int CMP_BITS = ((COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS) + 1;
	// Raw event value width
	localparam int VAL_BITS = 16;

	// Event kinds
	typedef enum logic [2:0] {
		MODE_SLOT   = 3'd0,
		MODE_X      = 3'd1,
		MODE_Y      = 3'd2,
		MODE_TRACK  = 3'd3,
		MODE_BUTTON = 3'd4,
		MODE_OTHER  = 3'd5
	} mode_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ENABLE        = 3'd0,
		REG_SLEEP_ONLY    = 3'd1,
		REG_LEFT_TRIGGER  = 3'd2,
		REG_RIGHT_TRIGGER = 3'd3,
		REG_X_LIMIT       = 3'd4,
		REG_Y_LIMIT       = 3'd5
	} reg_idx_t;

	// Current configuration
	typedef struct packed {
		logic                enable;
		logic                sleep_only;
		logic [THR_BITS-1:0] left_trigger;
		logic [THR_BITS-1:0] right_trigger;
		logic [THR_BITS-1:0] x_limit;
		logic [THR_BITS-1:0] y_limit;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic power_pulse;
		logic direction;
	} result_t;

	// Sign-extend or wrap a raw event value to coordinate width
	function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [VAL_BITS-1:0] raw);
		logic signed [COORD_BITS-1:0] r;
		for (int i = 0; i < COORD_BITS; i++) begin
			r[i] = (i < VAL_BITS) ? raw[i] : raw[VAL_BITS-1];
		end
		return r;
	endfunction

	// Coordinate to compare width
	function automatic logic signed [CMP_BITS-1:0] sx(input logic signed [COORD_BITS-1:0] v);
		return CMP_BITS'(v);
	endfunction

	// Threshold to compare width
	function automatic logic signed [CMP_BITS-1:0] zx(input logic [THR_BITS-1:0] v);
		return $signed({{(CMP_BITS-THR_BITS){1'b0}}, v});
	endfunction

endpackage

// File: src/swipe_wake_gesture_detector.sv
// Swipe gesture detector: takes one decoded touch event word per cycle while
// s_tready is high and returns one result word for each, in order. An event is
// held in the input register and is evaluated on its way into the output
// register; the output register lets a new word enter while a result waits to
// be taken. The gesture state (latched coordinates, barriers, armed flag)
// updates as a word moves from the input register to the output register.
// Configuration is to be written through the index/data port by the user only
// while no word is in flight; the block itself does not enforce it.
module swipe_wake_gesture_detector import swd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [23:0]         s_tdata,   // event_value[15:0], screen_off[16], zero pad
	input  logic [2:0]          s_tuser,   // mode[2:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // power_pulse[0], direction[1], zero pad
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [THR_BITS-1:0] cfg_wdata
);

	cfg_t    cfg;
	result_t res;

	logic                s1_valid;
	logic [2:0]          mode_s1;
	logic [VAL_BITS-1:0] value_s1;
	logic                scr_off_s1;
	logic                out_valid_q;
	result_t             out_q;
	logic                adv;

	swd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Word moves on when the output register is free or being emptied
	assign adv      = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1    <= s_tuser;
			value_s1   <= s_tdata[VAL_BITS-1:0];
			scr_off_s1 <= s_tdata[VAL_BITS];
		end
	end

	swd_eval u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.mode        (mode_s1),
		.event_value (value_s1),
		.screen_off  (scr_off_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.direction, out_q.power_pulse};

`ifndef NO_ASSERTIONS
	// A waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !adv)
		else $error("result overwritten while stalled");

	// Input register never accepts while holding a stalled word
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_valid_q && !m_tready |-> !s_tready)
		else $error("input register overrun");
`endif

endmodule

// File: src/swd_cfg_regs.sv
module swd_cfg_regs import swd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [THR_BITS-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	// Register file, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b1;
			cfg_q.sleep_only    <= 1'b1;
			cfg_q.left_trigger  <= THR_BITS'(60);
			cfg_q.right_trigger <= THR_BITS'(420);
			cfg_q.x_limit       <= THR_BITS'(480);
			cfg_q.y_limit       <= THR_BITS'(854);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:        cfg_q.enable        <= cfg_wdata[0];
				REG_SLEEP_ONLY:    cfg_q.sleep_only    <= cfg_wdata[0];
				REG_LEFT_TRIGGER:  cfg_q.left_trigger  <= cfg_wdata;
				REG_RIGHT_TRIGGER: cfg_q.right_trigger <= cfg_wdata;
				REG_X_LIMIT:       cfg_q.x_limit       <= cfg_wdata;
				REG_Y_LIMIT:       cfg_q.y_limit       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/swd_eval.sv
module swd_eval import swd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [2:0]          mode,
	input  logic [VAL_BITS-1:0] event_value,
	input  logic                screen_off,
	input  cfg_t                cfg,
	output result_t             res
);

	logic signed [COORD_BITS-1:0] x_q, y_q, x_d, y_d;
	logic xs_q, ys_q, fb_q, sb_q, armed_q;
	logic xs_d, ys_d, fb_d, sb_d, armed_d;

	logic rearm_ev, both, wake_en, sleep_en, active;
	logic signed [CMP_BITS-1:0] x, y, lt, rt, xl, yl;
	logic y_ok, z1, z2, z3, fb_hit, sb_hit, fire;

	// Event decode and coordinate latch
	always_comb begin
		rearm_ev = (mode == MODE_SLOT) ||
			((mode == MODE_TRACK) && (event_value == {VAL_BITS{1'b1}})) ||
			((mode == MODE_BUTTON) && (event_value == '0));
		x_d  = (mode == MODE_X) ? to_coord(event_value) : x_q;
		y_d  = (mode == MODE_Y) ? to_coord(event_value) : y_q;
		both = !rearm_ev && (xs_q || (mode == MODE_X)) && (ys_q || (mode == MODE_Y));
	end

	// Zone tests against the newly latched pair
	always_comb begin
		x  = sx(x_d);
		y  = sx(y_d);
		lt = zx(cfg.left_trigger);
		rt = zx(cfg.right_trigger);
		xl = zx(cfg.x_limit);
		yl = zx(cfg.y_limit);
		wake_en  = screen_off && cfg.enable && !cfg.sleep_only;
		sleep_en = !screen_off && cfg.enable;
		y_ok = (y > 0) && (y < yl);
		if (wake_en) begin
			z1 = (x > 0) && (x < lt);
			z2 = (x > lt) && (x < rt);
			z3 = (x > rt);
		end else begin
			z1 = (x < xl) && (x > rt);
			z2 = (x < rt) && (x > lt);
			z3 = (x < lt);
		end
		active = both && (wake_en || sleep_en);
		fb_hit = fb_q || (z1 && y_ok);
		sb_hit = sb_q || (z2 && y_ok);
		fire   = active && fb_hit && sb_hit && z3 && y_ok && armed_q;
	end

	// Next state of the gesture tracker
	always_comb begin
		xs_d    = xs_q;
		ys_d    = ys_q;
		fb_d    = fb_q;
		sb_d    = sb_q;
		armed_d = armed_q;
		if (rearm_ev) begin
			armed_d = 1'b1;
			fb_d    = 1'b0;
			sb_d    = 1'b0;
		end else if (both) begin
			xs_d = 1'b0;
			ys_d = 1'b0;
			if (active && fb_hit) begin
				fb_d = 1'b1;
				if (sb_hit) begin
					sb_d = 1'b1;
				end
			end
			if (fire) begin
				armed_d = 1'b0;
			end
		end else begin
			xs_d = xs_q || (mode == MODE_X);
			ys_d = ys_q || (mode == MODE_Y);
		end
	end

	// Result for the word under evaluation
	always_comb begin
		res.power_pulse = fire;
		res.direction   = fire && !wake_en;
	end

	// State registers, moved on each advancing word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			xs_q    <= 1'b0;
			ys_q    <= 1'b0;
			fb_q    <= 1'b0;
			sb_q    <= 1'b0;
			armed_q <= 1'b1;
		end else if (adv) begin
			x_q     <= x_d;
			y_q     <= y_d;
			xs_q    <= xs_d;
			ys_q    <= ys_d;
			fb_q    <= fb_d;
			sb_q    <= sb_d;
			armed_q <= armed_d;
		end
	end

`ifndef NO_ASSERTIONS
	// A pulse needs the trigger armed and then disarms it
	a_pulse_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.power_pulse |=> !armed_q)
		else $error("pulse did not disarm the trigger");

	// A re-arm event clears both barriers
	a_rearm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && rearm_ev |=> armed_q && !fb_q && !sb_q)
		else $error("re-arm left barriers set");

	// The second barrier never stands without the first
	a_barrier_order: assert property (@(posedge clk) disable iff (!arst_n)
		sb_q |-> fb_q)
		else $error("second barrier set without first");

	// A completed pair is always consumed at once
	a_pair_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		!(xs_q && ys_q))
		else $error("coordinate pair left pending");
`endif

endmodule

// File: dv/swipe_wake_gesture_detector_tb.sv
`timescale 1ns / 100ps

module swipe_wake_gesture_detector_tb;
	import swd_pkg::*;

	// Mode codes beyond the defined kinds; the block must ignore them
	localparam logic [2:0]  MODE_SPARE_A = 3'd6;
	localparam logic [2:0]  MODE_SPARE_B = 3'd7;
	// Event values with a meaning of their own
	localparam logic [15:0] LIFT_ID      = 16'hFFFF;
	localparam logic [15:0] BTN_UP       = 16'h0000;
	localparam logic        DIR_WAKE     = 1'b0;
	localparam logic        DIR_SLEEP    = 1'b1;
	localparam int          X_MAX        = 32767;
	localparam int          MAX_WAIT     = 18;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] value;
		logic        off;
		logic        hold;   // wait for every pending result before sending
	} touch_evt_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [23:0]         s_tdata = '0;   // event_value[15:0], screen_off[16], zero pad
	logic [2:0]          s_tuser = '0;   // mode[2:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;        // power_pulse[0], direction[1], zero pad
	logic                cfg_we = 1'b0;
	logic [2:0]          cfg_index = '0;
	logic [THR_BITS-1:0] cfg_wdata = '0;

	swipe_wake_gesture_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Words waiting to be sent, and results waiting to be seen
	touch_evt_t touch_q[$];
	result_t    pulse_q[$];
	int         queued_cnt = 0;
	int         sent_cnt = 0;
	int         checked_cnt = 0;
	int         errors = 0;

	// Detector copy: configuration and gesture state
	cfg_t                         det_cfg = '{1'b1, 1'b1, 15'd60, 15'd420, 15'd480, 15'd854};
	logic signed [COORD_BITS-1:0] x_pos = '0;
	logic signed [COORD_BITS-1:0] y_pos = '0;
	logic                         x_seen = 1'b0;
	logic                         y_seen = 1'b0;
	logic                         barrier1 = 1'b0;
	logic                         barrier2 = 1'b0;
	logic                         armed = 1'b1;

	// Predict the result of one event and advance the gesture state
	function automatic result_t gesture_step(input logic [2:0] m, input logic [15:0] raw,
			input logic off);
		result_t r;
		int      x, y, lt, rt, xl, yl;
		logic    y_ok;
		r = '0;
		if (m == MODE_SLOT || (m == MODE_TRACK && raw == LIFT_ID) ||
				(m == MODE_BUTTON && raw == BTN_UP)) begin
			armed = 1'b1;
			barrier1 = 1'b0;
			barrier2 = 1'b0;
		end else begin
			if (m == MODE_X) begin
				x_pos = COORD_BITS'($signed(raw));
				x_seen = 1'b1;
			end
			if (m == MODE_Y) begin
				y_pos = COORD_BITS'($signed(raw));
				y_seen = 1'b1;
			end
			// sweep is judged only once both coordinates are in
			if (x_seen && y_seen) begin
				x_seen = 1'b0;
				y_seen = 1'b0;
				x = x_pos;
				y = y_pos;
				lt = int'(det_cfg.left_trigger);
				rt = int'(det_cfg.right_trigger);
				xl = int'(det_cfg.x_limit);
				yl = int'(det_cfg.y_limit);
				y_ok = (y > 0) && (y < yl);
				if (off && det_cfg.enable && !det_cfg.sleep_only) begin
					if (barrier1 || (x > 0 && x < lt && y_ok)) begin
						barrier1 = 1'b1;
						if (barrier2 || (x > lt && x < rt && y_ok)) begin
							barrier2 = 1'b1;
							if (x > rt && y_ok && armed) begin
								armed = 1'b0;
								r.power_pulse = 1'b1;
								r.direction = DIR_WAKE;
							end
						end
					end
				end else if (!off && det_cfg.enable) begin
					if (barrier1 || (x < xl && x > rt && y_ok)) begin
						barrier1 = 1'b1;
						if (barrier2 || (x < rt && x > lt && y_ok)) begin
							barrier2 = 1'b1;
							if (x < lt && y_ok && armed) begin
								armed = 1'b0;
								r.power_pulse = 1'b1;
								r.direction = DIR_SLEEP;
							end
						end
					end
				end
			end
		end
		return r;
	endfunction

	// Per-word wait, with quiet stretches where nobody idles
	function automatic int draw_wait(inout bit quiet, inout int left);
		if (left == 0) begin
			left = $urandom_range(8, 48);
			quiet = ($urandom_range(0, 3) == 0);
		end
		left--;
		return quiet ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// Source side
	touch_evt_t cur = '0;
	int         src_wait = 0;
	int         src_left = 0;
	bit         src_quiet = 1'b0;
	logic       src_acc;
	logic       src_tv;

	always @(posedge clk) begin
		if (arst_n) begin
			src_acc = s_tvalid && s_tready;
			src_tv = s_tvalid && !src_acc;
			if (src_acc) begin
				pulse_q.push_back(gesture_step(cur.mode, cur.value, cur.off));
				sent_cnt <= sent_cnt + 1;
				src_wait = draw_wait(src_quiet, src_left);
			end else if (src_wait > 0) begin
				src_wait--;
			end
			if (!src_tv && src_wait == 0 && touch_q.size() > 0 &&
					(!touch_q[0].hold || (!src_acc && sent_cnt == checked_cnt))) begin
				cur = touch_q.pop_front();
				src_tv = 1'b1;
			end
			s_tvalid <= src_tv;
			s_tdata <= {7'b0, cur.off, cur.value};
			s_tuser <= cur.mode;
		end
	end

	// Sink side: stall, then check each word against the oldest prediction
	int      snk_wait = 0;
	int      snk_left = 0;
	bit      snk_quiet = 1'b0;
	logic    snk_rdy;
	result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pulse_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word %b at %0t", m_tdata[1:0], $realtime);
				end else begin
					want = pulse_q.pop_front();
					if (m_tdata[0] !== want.power_pulse || m_tdata[1] !== want.direction) begin
						errors++;
						if (errors <= 10)
							$display("result %0d: pulse exp %b got %b, dir exp %b got %b",
								checked_cnt, want.power_pulse, m_tdata[0],
								want.direction, m_tdata[1]);
					end
					checked_cnt <= checked_cnt + 1;
				end
				snk_wait = draw_wait(snk_quiet, snk_left);
				snk_rdy = (snk_wait == 0);
			end else begin
				snk_rdy = m_tready;
				if (!m_tready) begin
					if (snk_wait > 0)
						snk_wait--;
					if (snk_wait == 0)
						snk_rdy = 1'b1;
				end
			end
			m_tready <= snk_rdy;
		end
	end

	// Stimulus helpers
	task automatic put(input logic [2:0] m, input int v, input logic off, input bit hold = 1'b0);
		touch_evt_t e;
		e.mode = m;
		e.value = 16'(v);
		e.off = off;
		e.hold = hold || ($urandom_range(0, 60) == 0);
		touch_q.push_back(e);
		queued_cnt++;
	endtask

	function automatic int rand16();
		return int'($urandom_range(0, 65535));
	endfunction

	function automatic int pick(input int lo, input int hi);
		if (lo > hi)
			return rand16() - 32768;
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	task automatic put_xy(input int x, input int y, input logic off);
		if ($urandom_range(0, 1)) begin
			put(MODE_X, x, off);
			put(MODE_Y, y, off);
		end else begin
			put(MODE_Y, y, off);
			put(MODE_X, x, off);
		end
	endtask

	task automatic put_rearm(input logic off);
		case ($urandom_range(0, 2))
			0: put(MODE_SLOT, rand16(), off);
			1: put(MODE_TRACK, LIFT_ID, off);
			default: put(MODE_BUTTON, BTN_UP, off);
		endcase
	endtask

	task automatic put_noise(input logic off);
		int v;
		v = rand16();
		case ($urandom_range(0, 6))
			0: put(MODE_OTHER, v, off);
			1: put($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B, v, off);
			2: put(MODE_TRACK, (16'(v) == LIFT_ID) ? 0 : v, off);
			3: put(MODE_BUTTON, (16'(v) == BTN_UP) ? 1 : v, off);
			4: put(MODE_X, v, off);
			5: put(MODE_Y, v, off);
			default: put_rearm(off);
		endcase
	endtask

	// x inside zone z of a wake (left to right) or sleep (right to left) sweep
	function automatic int zone_x(input logic off, input int z);
		int lt, rt, xl;
		lt = int'(det_cfg.left_trigger);
		rt = int'(det_cfg.right_trigger);
		xl = int'(det_cfg.x_limit);
		// boundaries themselves now and then
		if ($urandom_range(0, 11) == 0)
			return (z == 0) ? lt : (z == 1) ? rt : xl;
		if (off) begin
			case (z)
				0: return pick(1, lt - 1);
				1: return pick(lt + 1, rt - 1);
				default: return pick(rt + 1, X_MAX);
			endcase
		end
		case (z)
			0: return pick(rt + 1, xl - 1);
			1: return pick(lt + 1, rt - 1);
			default: return ($urandom_range(0, 7) == 0) ? pick(-32768, lt - 1) : pick(0, lt - 1);
		endcase
	endfunction

	// One sweep through the three zones, with the odd broken step
	task automatic put_swipe(input logic off);
		int yl, x, y, z;
		yl = int'(det_cfg.y_limit);
		if ($urandom_range(0, 7) != 0)
			put_rearm(off);
		for (int zi = 0; zi < 3; zi++) begin
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 9) == 0)
					put_noise(off);
				z = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : zi;
				x = zone_x(off, z);
				case ($urandom_range(0, 15))
					0: y = 0;
					1: y = yl;
					2: y = pick(-32768, -1);
					default: y = pick(1, yl - 1);
				endcase
				put_xy(x, y, ($urandom_range(0, 19) == 0) ? !off : off);
			end
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= THR_BITS'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENABLE:        det_cfg.enable = val[0];
			REG_SLEEP_ONLY:    det_cfg.sleep_only = val[0];
			REG_LEFT_TRIGGER:  det_cfg.left_trigger = THR_BITS'(val);
			REG_RIGHT_TRIGGER: det_cfg.right_trigger = THR_BITS'(val);
			REG_X_LIMIT:       det_cfg.x_limit = THR_BITS'(val);
			REG_Y_LIMIT:       det_cfg.y_limit = THR_BITS'(val);
			default: ;
		endcase
	endtask

	// Wait until every queued word has been sent and its result seen
	task automatic settle();
		do @(posedge clk); while (sent_cnt != queued_cnt || checked_cnt != queued_cnt);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic en, input logic so, input int lt, input int rt,
			input int xl, input int yl, input int n_words);
		int start;
		logic off;
		settle();
		write_reg(REG_ENABLE, en);
		write_reg(REG_SLEEP_ONLY, so);
		write_reg(REG_LEFT_TRIGGER, lt);
		write_reg(REG_RIGHT_TRIGGER, rt);
		write_reg(REG_X_LIMIT, xl);
		write_reg(REG_Y_LIMIT, yl);
		@(negedge clk);
		start = queued_cnt;
		while (queued_cnt - start < n_words) begin
			off = so ? ($urandom_range(0, 4) == 0) : $urandom_range(0, 1);
			if ($urandom_range(0, 3) != 0)
				put_swipe(off);
			else
				repeat ($urandom_range(1, 4)) put_noise(off);
		end
	endtask

	function automatic int near_span(input int base, input int span);
		return base + int'($urandom_range(2, span));
	endfunction

	// Main sequence
	int lt_r, rt_r, xl_r;

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset configuration, sleep sweep only
		put(MODE_SLOT, 16'h0000, 1'b0);
		put(MODE_X, 450, 1'b0);
		put(MODE_Y, 100, 1'b0);
		put(MODE_Y, 100, 1'b0);
		put(MODE_X, 200, 1'b0);
		put(MODE_X, 30, 1'b0);
		put(MODE_Y, 100, 1'b0);
		// no second pulse without a re-arm
		put(MODE_X, 30, 1'b0);
		put(MODE_Y, 100, 1'b0);
		put(MODE_TRACK, 5, 1'b0);
		put(MODE_TRACK, LIFT_ID, 1'b0);
		put(MODE_BUTTON, 1, 1'b0);
		put(MODE_BUTTON, BTN_UP, 1'b0);
		put(MODE_OTHER, 16'h7FFF, 1'b0);
		put(MODE_SPARE_A, 16'h8000, 1'b0);
		put(MODE_SPARE_B, 16'hFFFF, 1'b1);
		// re-arm keeps a half-seen coordinate pair
		put(MODE_X, 16'h8000, 1'b0);
		put(MODE_SLOT, 16'hFFFF, 1'b0);
		put(MODE_Y, 16'h7FFF, 1'b0);
		// wake sweep disabled by sleep_only, pair still consumed
		put(MODE_X, 16'hFFFF, 1'b1);
		put(MODE_Y, 16'h0000, 1'b1);
		put(MODE_X, 30, 1'b1, 1'b1);
		put(MODE_Y, 100, 1'b1);

		// random phases over a range of settings
		run_phase(1'b1, 1'b0, 60, 420, 480, 854, 100);
		lt_r = $urandom_range(1, 8000);
		rt_r = near_span(lt_r, 12000);
		xl_r = near_span(rt_r, 12000);
		run_phase(1'b1, 1'b0, lt_r, rt_r, xl_r, $urandom_range(2, X_MAX), 100);
		lt_r = $urandom_range(1, 300);
		rt_r = near_span(lt_r, 600);
		xl_r = near_span(rt_r, 300);
		run_phase(1'b1, 1'b1, lt_r, rt_r, xl_r, $urandom_range(2, 2000), 100);
		run_phase(1'b0, 1'b0, lt_r, rt_r, xl_r, $urandom_range(2, 2000), 100);
		run_phase(1'b1, 1'b0, 0, X_MAX, X_MAX, X_MAX, 100);
		run_phase(1'b1, 1'b0, 0, 0, 0, 0, 60);
		lt_r = $urandom_range(1, 200);
		rt_r = near_span(lt_r, 400);
		xl_r = near_span(rt_r, 200);
		run_phase(1'b1, 1'b0, lt_r, rt_r, xl_r, $urandom_range(2, 1000), 120);

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0 && pulse_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#1000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
